/* rtl/assert_macros.svh */
// Assertion macros shared by the decoder RTL.
// Expects signals named clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/lsd_pkg.sv */
// Shared types and constants for the LZSS stream decoder.
// No dependencies; used by the interfaces, controller, datapath and top level.
package lsd_pkg;

    localparam int HISTORY_DEPTH_DEF = 4096;
    localparam int BYTE_W            = 8;
    localparam int DIST_W            = 12;
    localparam int LEN_W             = 4;
    localparam int FLAGS_LEFT_W      = 4;
    localparam int FLAGS_PER_GROUP   = 8;
    // Wide enough for any distance and any fill count up to 4096.
    localparam int CMP_W             = 13;

    typedef enum logic [2:0] {
        ST_FLAG,
        ST_TOKEN,
        ST_MATCH_LOW,
        ST_COPY_RD,
        ST_COPY_WR
    } state_t;

    typedef enum logic [1:0] {
        EMIT_LIT,
        EMIT_COPY,
        EMIT_END,
        EMIT_BAD
    } emit_kind_t;

    typedef struct packed {
        logic       load_flags;
        logic       take_token;
        logic       load_high;
        logic       load_match;
        logic       mem_read;
        logic       push_lit;
        logic       push_copy;
        logic       clear_hist;
        logic       emit;
        emit_kind_t kind;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic token_bit;
        logic byte_zero;
        logic bad_ref;
        logic len_zero;
        logic flags_le1;
        logic flags_zero;
        logic copy_last;
    } stat_t;

endpackage

/* rtl/lsd_if.sv */
// Valid/ready channel interfaces for the decoder's input and output streams.
// Depends on lsd_pkg for field widths.
interface lsd_in_if;
    import lsd_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface lsd_out_if;
    import lsd_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              last_of_run;
    logic              end_of_stream;
    logic              bad_reference;

    modport source (output valid, output out_byte, output last_of_run,
                    output end_of_stream, output bad_reference, input ready);
    modport sink   (input valid, input out_byte, input last_of_run,
                    input end_of_stream, input bad_reference, output ready);
endinterface

/* rtl/lsd_ctrl.sv */
// Decoder controller: stream phase and copy sequencing state machine.
// Depends on lsd_pkg and assert_macros.svh; drives the datapath through cmd_t.
`include "assert_macros.svh"

module lsd_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  lsd_pkg::stat_t stat,
    output lsd_pkg::cmd_t  cmd
);
    import lsd_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;
    logic   input_state;

    assign input_state = (state_reg == ST_FLAG) || (state_reg == ST_TOKEN) ||
                         (state_reg == ST_MATCH_LOW);
    assign in_ready    = input_state && stat.out_free;
    assign accept      = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            state_reg <= ST_FLAG;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_FLAG:
            begin
                if (accept)
                    state_next = ST_TOKEN;
            end
            ST_TOKEN:
            begin
                if (accept)
                begin
                    if (stat.token_bit)
                        state_next = ST_MATCH_LOW;
                    else if (stat.byte_zero)
                        state_next = ST_FLAG;
                    else
                        state_next = stat.flags_le1 ? ST_FLAG : ST_TOKEN;
                end
            end
            ST_MATCH_LOW:
            begin
                if (accept)
                begin
                    if (stat.bad_ref || stat.len_zero)
                        state_next = stat.flags_zero ? ST_FLAG : ST_TOKEN;
                    else
                        state_next = ST_COPY_RD;
                end
            end
            ST_COPY_RD:
            begin
                state_next = ST_COPY_WR;
            end
            ST_COPY_WR:
            begin
                if (stat.out_free)
                begin
                    if (stat.copy_last)
                        state_next = stat.flags_zero ? ST_FLAG : ST_TOKEN;
                    else
                        state_next = ST_COPY_RD;
                end
            end
            default:
            begin
                state_next = ST_FLAG;
            end
        endcase
    end

    // Commands
    always_comb
    begin
        cmd      = '0;
        cmd.kind = EMIT_LIT;
        case (state_reg)
            ST_FLAG:
            begin
                cmd.load_flags = accept;
            end
            ST_TOKEN:
            begin
                if (accept)
                begin
                    cmd.take_token = 1'b1;
                    if (stat.token_bit)
                    begin
                        cmd.load_high = 1'b1;
                    end
                    else if (stat.byte_zero)
                    begin
                        cmd.clear_hist = 1'b1;
                        cmd.emit       = 1'b1;
                        cmd.kind       = EMIT_END;
                    end
                    else
                    begin
                        cmd.push_lit = 1'b1;
                        cmd.emit     = 1'b1;
                        cmd.kind     = EMIT_LIT;
                    end
                end
            end
            ST_MATCH_LOW:
            begin
                if (accept)
                begin
                    if (stat.bad_ref)
                    begin
                        cmd.emit = 1'b1;
                        cmd.kind = EMIT_BAD;
                    end
                    else if (!stat.len_zero)
                    begin
                        cmd.load_match = 1'b1;
                    end
                end
            end
            ST_COPY_RD:
            begin
                cmd.mem_read = 1'b1;
            end
            ST_COPY_WR:
            begin
                if (stat.out_free)
                begin
                    cmd.push_copy = 1'b1;
                    cmd.emit      = 1'b1;
                    cmd.kind      = EMIT_COPY;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    `ASSERT_NEXT(a_rd_then_wr, state_reg == ST_COPY_RD, state_reg == ST_COPY_WR,
        "history read not followed by its write step")
    `ASSERT_ALWAYS(a_emit_needs_slot, !cmd.emit || stat.out_free,
        "result emitted while output register still full")
    `ASSERT_ALWAYS(a_one_push, !(cmd.push_lit && cmd.push_copy),
        "two history writes in one cycle")

endmodule

/* rtl/lsd_datapath.sv */
// Decoder datapath: flag register, match registers, history RAM, output register.
// Depends on lsd_pkg, lsd_if and assert_macros.svh; controlled by lsd_ctrl.
`include "assert_macros.svh"

module lsd_datapath #(
    parameter int HISTORY_DEPTH = lsd_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [lsd_pkg::BYTE_W-1:0] in_byte,
    input  lsd_pkg::cmd_t             cmd,
    output lsd_pkg::stat_t            stat,
    lsd_out_if.source                 out_ch
);
    import lsd_pkg::*;

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int FW = $clog2(HISTORY_DEPTH + 1);

    logic [BYTE_W-1:0]       flag_bits_reg, flag_bits_next;
    logic [FLAGS_LEFT_W-1:0] flags_left_reg, flags_left_next;
    logic [BYTE_W-1:0]       high_reg;
    logic [DIST_W-1:0]       dist_reg;
    logic [LEN_W-1:0]        cnt_reg;
    logic [AW-1:0]           wp_reg, wp_next;
    logic [FW-1:0]           fill_reg, fill_next;
    logic [BYTE_W-1:0]       rd_data_reg;
    logic                    out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]       out_byte_reg;
    logic                    out_last_reg;
    logic                    out_end_reg;
    logic                    out_bad_reg;

    logic [BYTE_W-1:0] mem [HISTORY_DEPTH];

    logic [DIST_W-1:0] dist_in;
    logic [CMP_W:0]    back_sum;
    logic [CMP_W:0]    back_wrap;
    logic [AW-1:0]     rd_addr;
    logic              we;
    logic [BYTE_W-1:0] wdata;

    assign dist_in = {high_reg, in_byte[BYTE_W-1:LEN_W]};

    assign stat.out_free   = !out_valid_reg || out_ch.ready;
    assign stat.token_bit  = flag_bits_reg[BYTE_W-1];
    assign stat.byte_zero  = (in_byte == '0);
    assign stat.bad_ref    = (dist_in == '0) ||
                             ({1'b0, dist_in} > CMP_W'(fill_reg));
    assign stat.len_zero   = (in_byte[LEN_W-1:0] == '0);
    assign stat.flags_le1  = (flags_left_reg <= FLAGS_LEFT_W'(1));
    assign stat.flags_zero = (flags_left_reg == '0);
    assign stat.copy_last  = (cnt_reg == LEN_W'(1));

    // Copy source: write pointer minus distance, modulo the ring depth.
    assign back_sum  = (CMP_W + 1)'(wp_reg) + (CMP_W + 1)'(HISTORY_DEPTH) -
                       (CMP_W + 1)'(dist_reg);
    assign back_wrap = (back_sum >= (CMP_W + 1)'(HISTORY_DEPTH)) ?
                       back_sum - (CMP_W + 1)'(HISTORY_DEPTH) : back_sum;
    assign rd_addr   = back_wrap[AW-1:0];

    assign we    = cmd.push_lit || cmd.push_copy;
    assign wdata = cmd.push_copy ? rd_data_reg : in_byte;

    always_comb
    begin
        flag_bits_next  = flag_bits_reg;
        flags_left_next = flags_left_reg;
        if (cmd.load_flags)
        begin
            flag_bits_next  = in_byte;
            flags_left_next = FLAGS_LEFT_W'(FLAGS_PER_GROUP);
        end
        else if (cmd.clear_hist)
        begin
            flag_bits_next  = '0;
            flags_left_next = '0;
        end
        else if (cmd.take_token)
        begin
            flag_bits_next = {flag_bits_reg[BYTE_W-2:0], 1'b0};
            if (flags_left_reg != '0)
                flags_left_next = flags_left_reg - FLAGS_LEFT_W'(1);
        end
    end

    always_comb
    begin
        wp_next   = wp_reg;
        fill_next = fill_reg;
        if (cmd.clear_hist)
        begin
            wp_next   = '0;
            fill_next = '0;
        end
        else if (we)
        begin
            wp_next = (wp_reg == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_reg + AW'(1);
            if (fill_reg != FW'(HISTORY_DEPTH))
                fill_next = fill_reg + FW'(1);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (out_ch.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            flag_bits_reg  <= '0;
            flags_left_reg <= '0;
            wp_reg         <= '0;
            fill_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            flag_bits_reg  <= flag_bits_next;
            flags_left_reg <= flags_left_next;
            wp_reg         <= wp_next;
            fill_reg       <= fill_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk) begin
        if (cmd.load_high)
            high_reg <= in_byte;
        if (cmd.load_match)
        begin
            dist_reg <= dist_in;
            cnt_reg  <= in_byte[LEN_W-1:0];
        end
        else if (cmd.push_copy)
        begin
            cnt_reg <= cnt_reg - LEN_W'(1);
        end
        if (cmd.emit)
        begin
            case (cmd.kind)
                EMIT_LIT:  out_byte_reg <= in_byte;
                EMIT_COPY: out_byte_reg <= rd_data_reg;
                default:   out_byte_reg <= '0;
            endcase
            out_last_reg <= (cmd.kind == EMIT_COPY) ? stat.copy_last : 1'b1;
            out_end_reg  <= (cmd.kind == EMIT_END);
            out_bad_reg  <= (cmd.kind == EMIT_BAD);
        end
    end

    // History ring
    always_ff @(posedge clk) begin
        if (we)
            mem[wp_reg] <= wdata;
        if (cmd.mem_read)
            rd_data_reg <= mem[rd_addr];
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.out_byte      = out_byte_reg;
    assign out_ch.last_of_run   = out_last_reg;
    assign out_ch.end_of_stream = out_end_reg;
    assign out_ch.bad_reference = out_bad_reg;

    `ASSERT_ALWAYS(a_fill_bound, fill_reg <= FW'(HISTORY_DEPTH),
        "fill count beyond history depth")
    `ASSERT_ALWAYS(a_read_in_range,
        !cmd.mem_read ||
        ((dist_reg != '0) && ({1'b0, dist_reg} <= CMP_W'(fill_reg))),
        "history read outside the written bytes")

endmodule

/* rtl/lzss_stream_decoder_unit.sv */
// Top level of the LZSS stream decoder: controller plus datapath.
// Depends on lsd_pkg, lsd_if, lsd_ctrl and lsd_datapath.
//
//  channel  | dir | payload                                            | handshake
//  ---------+-----+----------------------------------------------------+-----------
//  in_ch    | in  | in_byte[7:0]                                       | valid/ready
//  out_ch   | out | out_byte[7:0], last_of_run, end_of_stream,         | valid/ready
//           |     | bad_reference                                      |
//
// A flag byte, a literal or a match byte is taken when the output register is free or
// being drained. Each byte copied by a match is first read from the history RAM into a
// register, then written back at the head while its result is registered for output;
// that write step waits while the output register is still full.
// Reset clears the phase, flags, write pointer and fill count; the history RAM is
// not cleared, since only bytes written since the last start are ever read.
// A stalled output holds its result; input is refused until the slot frees up.

module lzss_stream_decoder_unit #(
    parameter int HISTORY_DEPTH = lsd_pkg::HISTORY_DEPTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    lsd_in_if.sink    in_ch,
    lsd_out_if.source out_ch
);
    import lsd_pkg::*;

    cmd_t  cmd;
    stat_t stat;
    logic  in_ready;

    // Sequence the stream phases and the per-byte copy steps.
    lsd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    assign in_ch.ready = in_ready;

    // Hold flags, match fields, history ring and the output register.
    lsd_datapath #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_byte (in_ch.in_byte),
        .cmd     (cmd),
        .stat    (stat),
        .out_ch  (out_ch)
    );

endmodule
